// ----- hdl/bsfb_pkg.sv -----
`default_nettype none

package bsfb_pkg;

  localparam int NUM_SLOTS  = 9;
  localparam int SLOT_CLOSE = 8;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_FLAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_0   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_1   = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       seq_bit;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] address_byte;
    logic [7:0] escape_byte;
    logic [7:0] escaped_flag_byte;
    logic [7:0] escaped_escape_byte;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    flag_byte:           8'd126,
    address_byte:        8'd3,
    escape_byte:         8'd125,
    escaped_flag_byte:   8'd94,
    escaped_escape_byte: 8'd93,
    control_seq_zero:    8'd0,
    control_seq_one:     8'd64
  };

  // fixed slots: flag, address, control, header check, data (2), check (2), closing flag
  typedef struct packed {
    logic [NUM_SLOTS-1:0]       mask;
    logic [NUM_SLOTS-1:0][7:0]  bytes;
  } slot_set_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
  } stuffed_t;

  function automatic stuffed_t stuff_byte(input logic [7:0] value, input cfg_t cfg);
    stuffed_t s;
    s.b0  = value;
    s.b1  = 8'd0;
    s.two = 1'b0;
    if (value == cfg.flag_byte) begin
      s.b0  = cfg.escape_byte;
      s.b1  = cfg.escaped_flag_byte;
      s.two = 1'b1;
    end else if (value == cfg.escape_byte) begin
      s.b0  = cfg.escape_byte;
      s.b1  = cfg.escaped_escape_byte;
      s.two = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/byte_stuffed_frame_builder.sv -----
`default_nettype none

// Byte-stuffing frame builder: each input word carries one raw payload byte,
// marked first/last, plus the sequence bit. The first byte of a frame emits
// flag, address, control and header check ahead of it; payload bytes equal to
// flag or escape go out as escape plus a substitute; after the last byte the
// stuffed XOR check and a closing flag follow. Bytes outside a frame produce
// nothing. One line byte leaves per cycle from the output register unless
// out_ready stalls it; a word makes at most nine line bytes, and a byte
// outside a frame passes as an empty slot set. The next word moves on in the
// cycle the final line byte of the previous one enters the output register.
// Plain mid-frame bytes sustain one word per cycle unless out_ready stalls.
// Words pass input, slot and output registers in turn. Config registers are
// written on cfg_we; write them only while the block is idle.
module byte_stuffed_frame_builder (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  bsfb_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  wire                              out_ready,
  output bsfb_pkg::out_word_t              out_word,
  input  wire                              cfg_we,
  input  wire [bsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [7:0]                        cfg_wdata
);
  import bsfb_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      slot_valid;
  logic      slot_ready;
  slot_set_t slot_set;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAG:     cfg_nxt.flag_byte           = cfg_wdata;
        CFG_ADDRESS:  cfg_nxt.address_byte        = cfg_wdata;
        CFG_ESCAPE:   cfg_nxt.escape_byte         = cfg_wdata;
        CFG_ESC_FLAG: cfg_nxt.escaped_flag_byte   = cfg_wdata;
        CFG_ESC_ESC:  cfg_nxt.escaped_escape_byte = cfg_wdata;
        CFG_CTRL_0:   cfg_nxt.control_seq_zero    = cfg_wdata;
        CFG_CTRL_1:   cfg_nxt.control_seq_one     = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfb_expand u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .cfg        (cfg_r),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot_set   (slot_set)
  );

  bsfb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot_set   (slot_set),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ----- hdl/bsfb_expand.sv -----
`default_nettype none

module bsfb_expand (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  bsfb_pkg::in_word_t    in_word,
  input  bsfb_pkg::cfg_t        cfg,
  output logic                  slot_valid,
  input  wire                   slot_ready,
  output bsfb_pkg::slot_set_t   slot_set
);
  import bsfb_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  in_word_t   in_word_r;
  logic [7:0] check_r, check_nxt;
  logic       open_r, open_nxt;

  logic       take;
  logic       active;
  logic [7:0] control;
  logic [7:0] check_new;
  stuffed_t   st_data, st_check;

  assign take     = in_valid_r && slot_ready;
  assign in_ready = !in_valid_r || slot_ready;

  always_comb begin
    active    = in_word_r.first_byte || open_r;
    control   = in_word_r.seq_bit ? cfg.control_seq_one : cfg.control_seq_zero;
    check_new = in_word_r.first_byte ? in_word_r.data_byte
                                     : (check_r ^ in_word_r.data_byte);
    st_data   = stuff_byte(in_word_r.data_byte, cfg);
    st_check  = stuff_byte(check_new, cfg);

    slot_set.bytes[0] = cfg.flag_byte;
    slot_set.bytes[1] = cfg.address_byte;
    slot_set.bytes[2] = control;
    slot_set.bytes[3] = cfg.address_byte ^ control;
    slot_set.bytes[4] = st_data.b0;
    slot_set.bytes[5] = st_data.b1;
    slot_set.bytes[6] = st_check.b0;
    slot_set.bytes[7] = st_check.b1;
    slot_set.bytes[8] = cfg.flag_byte;

    slot_set.mask[3:0] = {4{in_word_r.first_byte}};
    slot_set.mask[4]   = active;
    slot_set.mask[5]   = active && st_data.two;
    slot_set.mask[6]   = active && in_word_r.last_byte;
    slot_set.mask[7]   = active && in_word_r.last_byte && st_check.two;
    slot_set.mask[8]   = active && in_word_r.last_byte;

    // a byte outside any frame still passes, but with an empty slot set
    slot_valid = in_valid_r;

    in_valid_nxt = in_ready ? in_valid : in_valid_r;
    check_nxt    = check_r;
    open_nxt     = open_r;
    if (take && active) begin
      check_nxt = check_new;
      open_nxt  = !in_word_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      check_r    <= 8'd0;
      open_r     <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      check_r    <= check_nxt;
      open_r     <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_word;
    end
  end

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    take && active && in_word_r.last_byte |=> !open_r)
    else $error("frame still open after last byte");

  a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_word_r.first_byte && !in_word_r.last_byte |=> open_r)
    else $error("frame not open after first byte");

  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !slot_ready |=> in_valid_r)
    else $error("held word dropped while the emitter was busy");

endmodule

`default_nettype wire

// ----- hdl/bsfb_emit.sv -----
`default_nettype none

module bsfb_emit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   slot_valid,
  output logic                  slot_ready,
  input  bsfb_pkg::slot_set_t   slot_set,
  output logic                  out_valid,
  input  wire                   out_ready,
  output bsfb_pkg::out_word_t   out_word
);
  import bsfb_pkg::*;

  logic [NUM_SLOTS-1:0]      mask_r, mask_nxt;
  logic [NUM_SLOTS-1:0][7:0] bytes_r;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_word_r, out_word_nxt;

  logic                      out_adv;
  logic [NUM_SLOTS-1:0]      low;
  logic [NUM_SLOTS-1:0]      mask_after;
  logic                      load;

  assign out_adv    = !out_valid_r || out_ready;
  assign slot_ready = (mask_after == '0);
  assign load       = slot_valid && slot_ready;
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;

  always_comb begin
    // lowest pending slot goes out next
    low        = mask_r & (~mask_r + 1'b1);
    mask_after = out_adv ? (mask_r & ~low) : mask_r;

    out_word_nxt.out_byte = 8'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      out_word_nxt.out_byte = out_word_nxt.out_byte | (bytes_r[i] & {8{low[i]}});
    end
    out_word_nxt.run_last  = ((mask_r & ~low) == '0);
    out_word_nxt.frame_end = low[SLOT_CLOSE];

    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = (mask_r != '0);
    end
    mask_nxt = load ? slot_set.mask : mask_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= slot_set.bytes;
    end
    if (out_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_end |-> out_word_r.run_last)
    else $error("closing flag not marked as last word of its input");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_word_r.run_last |=> out_valid_r)
    else $error("gap inside the words of one input");

  a_pending_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.run_last |-> mask_r != '0)
    else $error("word not marked last but no slot pending");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bsfb_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FLAG;
  logic [7:0]           cfg_wdata = 8'd0;

  // idle knobs, changed by the stimulus between phases
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_phase     = 1'b0;
  logic hold_done      = 1'b0;
  int   hold_left      = 0;

  // frame builder copy: byte codes, running check, open flag
  cfg_t       cur_cfg  = CFG_RESET;
  logic [7:0] chk_acc  = 8'd0;
  logic       in_frame = 1'b0;

  in_word_t  payload_q[$];
  out_word_t line_due[$];
  out_word_t step_bytes[$];

  int errors      = 0;
  int idle_cycles = 0;

  byte_stuffed_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_line(logic [7:0] b, logic closing);
    out_word_t w;
    w.out_byte  = b;
    w.run_last  = 1'b0;
    w.frame_end = closing;
    step_bytes.push_back(w);
  endfunction

  function automatic void add_stuffed(logic [7:0] b);
    // flag compare has priority when flag and escape share a code
    if (b == cur_cfg.flag_byte) begin
      add_line(cur_cfg.escape_byte, 1'b0);
      add_line(cur_cfg.escaped_flag_byte, 1'b0);
    end else if (b == cur_cfg.escape_byte) begin
      add_line(cur_cfg.escape_byte, 1'b0);
      add_line(cur_cfg.escaped_escape_byte, 1'b0);
    end else begin
      add_line(b, 1'b0);
    end
  endfunction

  function automatic void predict_line_bytes(in_word_t w);
    logic [7:0] ctrl;
    step_bytes.delete();
    if (w.first_byte || in_frame) begin
      if (w.first_byte) begin
        ctrl = w.seq_bit ? cur_cfg.control_seq_one : cur_cfg.control_seq_zero;
        // header goes out unstuffed
        add_line(cur_cfg.flag_byte, 1'b0);
        add_line(cur_cfg.address_byte, 1'b0);
        add_line(ctrl, 1'b0);
        add_line(cur_cfg.address_byte ^ ctrl, 1'b0);
        chk_acc  = w.data_byte;
        in_frame = 1'b1;
      end else begin
        chk_acc = chk_acc ^ w.data_byte;
      end
      add_stuffed(w.data_byte);
      if (w.last_byte) begin
        add_stuffed(chk_acc);
        add_line(cur_cfg.flag_byte, 1'b1);
        in_frame = 1'b0;
      end
      step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      foreach (step_bytes[i]) line_due.push_back(step_bytes[i]);
    end
  endfunction

  always @(posedge clk) begin : drive
    bit offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_line_bytes(in_word);
      if (!in_valid || in_ready) begin
        offer = payload_q.size() != 0 && int'($urandom_range(99)) >= send_idle_pct;
        if (offer) in_word <= payload_q.pop_front();
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : receive
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_phase && !hold_done) begin
      // long back-pressure while the sender keeps offering
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= int'($urandom_range(99)) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin : monitor
    out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (line_due.size() == 0) begin
        $display("%0t: unexpected word: byte %h run_last %b frame_end %b", $time,
                 out_word.out_byte, out_word.run_last, out_word.frame_end);
        errors++;
      end else begin
        due = line_due.pop_front();
        if (out_word.out_byte !== due.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time,
                   due.out_byte, out_word.out_byte);
          errors++;
        end
        if (out_word.run_last !== due.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time,
                   due.run_last, out_word.run_last);
          errors++;
        end
        if (out_word.frame_end !== due.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time,
                   due.frame_end, out_word.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("byte_stuffed_frame_builder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(logic [7:0] d, logic f, logic l, logic s);
    in_word_t w;
    w.data_byte  = d;
    w.first_byte = f;
    w.last_byte  = l;
    w.seq_bit    = s;
    payload_q.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(CFG_FLAG, c.flag_byte);
    write_reg(CFG_ADDRESS, c.address_byte);
    write_reg(CFG_ESCAPE, c.escape_byte);
    write_reg(CFG_ESC_FLAG, c.escaped_flag_byte);
    write_reg(CFG_ESC_ESC, c.escaped_escape_byte);
    write_reg(CFG_CTRL_0, c.control_seq_zero);
    write_reg(CFG_CTRL_1, c.control_seq_one);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // block idle: nothing queued or pending, plus time for a dropped word to clear
  task automatic settle();
    while (payload_q.size() != 0 || in_valid || line_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.flag_byte           = 8'($urandom_range(255));
    c.address_byte        = 8'($urandom_range(255));
    c.escape_byte         = 8'($urandom_range(255));
    c.escaped_flag_byte   = 8'($urandom_range(255));
    c.escaped_escape_byte = 8'($urandom_range(255));
    c.control_seq_zero    = 8'($urandom_range(255));
    c.control_seq_one     = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) c.escape_byte = c.flag_byte;
    return c;
  endfunction

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 20) return cur_cfg.flag_byte;
    if (r < 35) return cur_cfg.escape_byte;
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed frames; some stray bytes and frames cut off without last
  task automatic queue_frames(int n);
    int         made;
    int         len;
    int         r;
    logic [7:0] acc;
    logic [7:0] d;
    logic       seq;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(19) == 0) ? int'($urandom_range(40, 11))
                                        : int'($urandom_range(10, 1));
        seq = 1'($urandom_range(1));
        acc = 8'd0;
        for (int i = 0; i < len; i++) begin
          d = pick_data();
          // steer the check onto a code that needs stuffing
          if (i == len - 1 && $urandom_range(4) == 0)
            d = acc ^ ($urandom_range(1) ? cur_cfg.flag_byte : cur_cfg.escape_byte);
          acc = acc ^ d;
          push_word(d, i == 0, (i == len - 1) && r >= 14,
                    (i == 0) ? seq : 1'($urandom_range(1)));
        end
        made += len;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default codes: flag 7e, escape 7d
    push_word(8'h7E, 1'b1, 1'b1, 1'b0);  // one-byte frame, data and check both stuffed
    push_word(8'h00, 1'b1, 1'b0, 1'b1);
    push_word(8'hFF, 1'b0, 1'b0, 1'b1);  // seq ignored mid-frame
    push_word(8'h7D, 1'b0, 1'b0, 1'b0);
    push_word(8'h7E, 1'b0, 1'b0, 1'b1);
    push_word(8'h55, 1'b0, 1'b1, 1'b0);
    push_word(8'h11, 1'b0, 1'b1, 1'b1);  // no frame open: dropped
    push_word(8'h22, 1'b0, 1'b0, 1'b0);
    push_word(8'hAA, 1'b1, 1'b0, 1'b0);
    push_word(8'h33, 1'b0, 1'b0, 1'b0);
    push_word(8'h44, 1'b1, 1'b0, 1'b1);  // restart abandons the open frame
    push_word(8'h5E, 1'b0, 1'b0, 1'b0);
    push_word(8'h67, 1'b0, 1'b1, 1'b0);  // check comes out as escape
    push_word(8'h12, 1'b1, 1'b0, 1'b0);
    push_word(8'h6C, 1'b0, 1'b1, 1'b1);  // check comes out as flag
    push_word(8'h01, 1'b1, 1'b1, 1'b1);
    push_word(8'h80, 1'b1, 1'b1, 1'b0);
    push_word(8'h5D, 1'b1, 1'b1, 1'b1);
    settle();

    load_cfg(random_cfg());
    send_idle_pct <= 70;
    queue_frames(90);
    settle();

    load_cfg('{flag_byte: 8'h00, address_byte: 8'h00, escape_byte: 8'hFF,
               escaped_flag_byte: 8'h00, escaped_escape_byte: 8'hFF,
               control_seq_zero: 8'h00, control_seq_one: 8'hFF});
    send_idle_pct  <= 0;
    recv_stall_pct <= 70;
    queue_frames(90);
    settle();

    // flag and escape share a code; address equals flag and stays unstuffed
    load_cfg('{flag_byte: 8'h55, address_byte: 8'h55, escape_byte: 8'h55,
               escaped_flag_byte: 8'hAA, escaped_escape_byte: 8'h55,
               control_seq_zero: 8'h7E, control_seq_one: 8'h7D});
    send_idle_pct  <= 7;
    recv_stall_pct <= 7;
    hold_phase     <= 1'b1;
    queue_frames(90);
    settle();

    load_cfg('{flag_byte: 8'hFF, address_byte: 8'hFF, escape_byte: 8'h00,
               escaped_flag_byte: 8'hFF, escaped_escape_byte: 8'h00,
               control_seq_zero: 8'hFF, control_seq_one: 8'h00});
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    queue_frames(90);
    settle();

    load_cfg(random_cfg());
    send_idle_pct  <= 7;
    recv_stall_pct <= 7;
    queue_frames(45);
    settle();
    load_cfg(CFG_RESET);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    queue_frames(45);
    settle();

    repeat (20) @(posedge clk);
    if (errors == 0 && line_due.size() == 0) begin
      $display("byte_stuffed_frame_builder: match");
    end else begin
      $display("%0d errors, %0d line bytes never seen", errors, line_due.size());
      $display("byte_stuffed_frame_builder: mismatch");
    end
    $finish;
  end

endmodule
